### hdl/rusi_pkg.sv
// Package with the shared types, register map and constants of the ray and unit sphere test.
`timescale 1ns / 1ps

package rusi_pkg;

   localparam int COORD_WIDTH   = 32;
   localparam int FRAC_BITS_DEF = 16;

   localparam int TOL_W      = 17;
   localparam int MAXD_W     = 31;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [TOL_W-1:0]  TOL_RESET  = 17'd66;
   localparam logic [MAXD_W-1:0] MAXD_RESET = 31'h7FFF_FFFF;

   // Register indexes, taken from byte address bit 2.
   localparam logic CSR_TOL_IDX  = 1'b0;
   localparam logic CSR_MAXD_IDX = 1'b1;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] origin_x;
      logic signed [COORD_WIDTH-1:0] origin_y;
      logic signed [COORD_WIDTH-1:0] origin_z;
      logic signed [COORD_WIDTH-1:0] dir_x;
      logic signed [COORD_WIDTH-1:0] dir_y;
      logic signed [COORD_WIDTH-1:0] dir_z;
   } rusi_req_type;

   typedef struct packed {
      logic                          hit;
      logic signed [COORD_WIDTH-1:0] depth_far;
      logic signed [COORD_WIDTH-1:0] depth_near;
   } rusi_rsp_type;

endpackage

### hdl/ray_unit_sphere_intersect_unit.sv
// Top level of the pipelined ray against unit sphere intersection test.
`timescale 1ns / 1ps

// Throughput: one ray per cycle, busy is never asserted.
// The result path runs through stages a, b and c, the d.d square root, the tca divider, stages e, f and g,
// the half chord square root, the two root dividers and the output register.
// Each result is on rsp_data for one cycle only, since the receiver cannot stall.
// Synchronous reset clears the pipeline valid bits and loads the register defaults.
module ray_unit_sphere_intersect_unit #(
   parameter int FRAC_BITS = rusi_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  rusi_pkg::rusi_req_type             req_data,
   output logic                               rsp_strobe,
   output rusi_pkg::rusi_rsp_type             rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rusi_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [rusi_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [rusi_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);

   localparam int CW     = rusi_pkg::COORD_WIDTH;
   localparam int TOL_W  = rusi_pkg::TOL_W;
   localparam int MAXD_W = rusi_pkg::MAXD_W;
   localparam int PROD_W = 2 * CW;
   localparam int SUM_W  = 2 * CW + 2;
   localparam int LEN_W  = CW + 1;
   localparam int T_W    = CW + 2;
   localparam int HALF_W = (T_W + 1) / 2;
   localparam int HI_W   = T_W - HALF_W;
   localparam int H2_W   = ((2 * FRAC_BITS > 2 * T_W) ? 2 * FRAC_BITS : 2 * T_W) + 2;
   localparam int HC_W   = H2_W / 2;
   localparam int NUM_W  = ((T_W > HC_W) ? T_W : HC_W) + 2;
   localparam int DV_W   = NUM_W + FRAC_BITS;
   localparam int RT_W   = DV_W + 1;

   localparam logic [SUM_W-1:0] ONE_SUM = {{(SUM_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);
   localparam logic [H2_W-1:0]  ONE_H2  = {{(H2_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);

   typedef struct packed {
      logic             dead;
      logic             org_in;
      logic             pd_neg;
      logic [SUM_W-1:0] pp;
      logic [SUM_W-1:0] pdm;
   } side1_type;

   typedef struct packed {
      logic             dead;
      logic             org_in;
      logic             pd_neg;
      logic [SUM_W-1:0] pp;
      logic [LEN_W-1:0] len;
   } side2_type;

   typedef struct packed {
      logic             dead;
      logic [T_W:0]     tca;
      logic [LEN_W-1:0] len;
   } side3_type;

   typedef struct packed {
      logic             dead;
      logic             neg1;
      logic             neg2;
      logic [LEN_W-1:0] len;
   } side4_type;

   // ---------------- configuration registers ----------------
   logic [TOL_W-1:0]  tol_ff;
   logic [MAXD_W-1:0] maxd_ff;
   logic              csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff  <= rusi_pkg::TOL_RESET;
         maxd_ff <= rusi_pkg::MAXD_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            rusi_pkg::CSR_TOL_IDX:  tol_ff  <= pwdata[TOL_W-1:0];
            rusi_pkg::CSR_MAXD_IDX: maxd_ff <= pwdata[MAXD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         rusi_pkg::CSR_TOL_IDX:  prdata = {{(rusi_pkg::CSR_DATA_W-TOL_W){1'b0}}, tol_ff};
         rusi_pkg::CSR_MAXD_IDX: prdata = {{(rusi_pkg::CSR_DATA_W-MAXD_W){1'b0}}, maxd_ff};
         default:                prdata = '0;
      endcase
   end

   // ---------------- stage a: magnitudes and signs ----------------
   assign busy = 1'b0;

   logic [CW-1:0] in_vec [0:5];
   assign in_vec[0] = req_data.origin_x;
   assign in_vec[1] = req_data.origin_y;
   assign in_vec[2] = req_data.origin_z;
   assign in_vec[3] = req_data.dir_x;
   assign in_vec[4] = req_data.dir_y;
   assign in_vec[5] = req_data.dir_z;

   logic          a_vld_ff;
   logic [CW-1:0] a_mag_ff [0:5];
   logic [2:0]    a_sx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 6; i++) begin
         a_mag_ff[i] <= in_vec[i][CW-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
      end
      for (int i = 0; i < 3; i++) begin
         a_sx_ff[i] <= in_vec[i][CW-1] ^ in_vec[i+3][CW-1];
      end
   end

   // ---------------- stage b: products ----------------
   logic              b_vld_ff;
   logic [PROD_W-1:0] b_dd_ff [0:2];
   logic [PROD_W-1:0] b_pp_ff [0:2];
   logic [PROD_W-1:0] b_pd_ff [0:2];
   logic [2:0]        b_sx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         b_dd_ff[i] <= a_mag_ff[i+3] * a_mag_ff[i+3];
         b_pp_ff[i] <= a_mag_ff[i] * a_mag_ff[i];
         b_pd_ff[i] <= a_mag_ff[i] * a_mag_ff[i+3];
      end
      b_sx_ff <= a_sx_ff;
   end

   // ---------------- stage c: dot product sums ----------------
   logic             c_vld_ff;
   logic [SUM_W-1:0] c_dd_ff, c_pp_ff, c_pos_ff, c_neg_ff;
   logic [SUM_W-1:0] pos_term [0:2];
   logic [SUM_W-1:0] neg_term [0:2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pos_term[i] = b_sx_ff[i] ? '0 : {2'b00, b_pd_ff[i]};
         neg_term[i] = b_sx_ff[i] ? {2'b00, b_pd_ff[i]} : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_dd_ff  <= {2'b00, b_dd_ff[0]} + {2'b00, b_dd_ff[1]} + {2'b00, b_dd_ff[2]};
      c_pp_ff  <= {2'b00, b_pp_ff[0]} + {2'b00, b_pp_ff[1]} + {2'b00, b_pp_ff[2]};
      c_pos_ff <= pos_term[0] + pos_term[1] + pos_term[2];
      c_neg_ff <= neg_term[0] + neg_term[1] + neg_term[2];
   end

   // ---------------- square root of d.d, one result bit per stage ----------------
   logic             s1_vld_ff  [0:LEN_W];
   logic [LEN_W:0]   s1_rem_ff  [0:LEN_W];
   logic [LEN_W-1:0] s1_root_ff [0:LEN_W];
   logic [SUM_W-1:0] s1_rad_ff  [0:LEN_W];
   side1_type        s1_side_ff [0:LEN_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff[0] <= 1'b0;
      end else begin
         s1_vld_ff[0] <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_rem_ff[0]         <= '0;
      s1_root_ff[0]        <= '0;
      s1_rad_ff[0]         <= c_dd_ff;
      s1_side_ff[0].dead   <= (c_dd_ff == '0);
      s1_side_ff[0].org_in <= (c_pp_ff < ONE_SUM);
      s1_side_ff[0].pd_neg <= (c_neg_ff > c_pos_ff);
      s1_side_ff[0].pp     <= c_pp_ff;
      s1_side_ff[0].pdm    <= (c_neg_ff > c_pos_ff) ? (c_neg_ff - c_pos_ff)
                                                    : (c_pos_ff - c_neg_ff);
   end

   for (genvar k = 0; k < LEN_W; k++) begin : g_sqrt1
      logic [LEN_W+1:0] cur;
      logic [LEN_W+1:0] trial;
      logic [LEN_W+1:0] diff;
      logic             ge;

      assign cur   = {s1_rem_ff[k][LEN_W-1:0], s1_rad_ff[k][SUM_W-1 -: 2]};
      assign trial = {s1_root_ff[k], 2'b01};
      assign diff  = cur - trial;
      assign ge    = (cur >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            s1_vld_ff[k+1] <= 1'b0;
         end else begin
            s1_vld_ff[k+1] <= s1_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         s1_rem_ff[k+1]  <= ge ? diff[LEN_W:0] : cur[LEN_W:0];
         s1_root_ff[k+1] <= {s1_root_ff[k][LEN_W-2:0], ge};
         s1_rad_ff[k+1]  <= {s1_rad_ff[k][SUM_W-3:0], 2'b00};
         s1_side_ff[k+1] <= s1_side_ff[k];
      end
   end

   // ---------------- divider for tca = |p.d| / L ----------------
   // The quotient is known to stay below 2^T_W, so the upper dividend bits start as remainder.
   logic             d1_vld_ff  [0:T_W];
   logic [LEN_W-1:0] d1_rem_ff  [0:T_W];
   logic [T_W-1:0]   d1_dvd_ff  [0:T_W];
   logic [T_W-1:0]   d1_q_ff    [0:T_W];
   side2_type        d1_side_ff [0:T_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_vld_ff[0] <= 1'b0;
      end else begin
         d1_vld_ff[0] <= s1_vld_ff[LEN_W];
      end
   end

   always_ff @(posedge clock) begin
      d1_rem_ff[0] <= {{(LEN_W-(SUM_W-T_W)){1'b0}}, s1_side_ff[LEN_W].pdm[SUM_W-1:T_W]};
      d1_dvd_ff[0] <= s1_side_ff[LEN_W].pdm[T_W-1:0];
      d1_q_ff[0]   <= '0;
      d1_side_ff[0].dead   <= s1_side_ff[LEN_W].dead;
      d1_side_ff[0].org_in <= s1_side_ff[LEN_W].org_in;
      d1_side_ff[0].pd_neg <= s1_side_ff[LEN_W].pd_neg;
      d1_side_ff[0].pp     <= s1_side_ff[LEN_W].pp;
      d1_side_ff[0].len    <= s1_root_ff[LEN_W];
   end

   for (genvar k = 0; k < T_W; k++) begin : g_div1
      logic [LEN_W:0] cur;
      logic [LEN_W:0] diff;
      logic           ge;

      assign cur  = {d1_rem_ff[k], d1_dvd_ff[k][T_W-1]};
      assign diff = cur - {1'b0, d1_side_ff[k].len};
      assign ge   = (cur >= {1'b0, d1_side_ff[k].len});

      always_ff @(posedge clock) begin
         if (reset) begin
            d1_vld_ff[k+1] <= 1'b0;
         end else begin
            d1_vld_ff[k+1] <= d1_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         d1_rem_ff[k+1]  <= ge ? diff[LEN_W-1:0] : cur[LEN_W-1:0];
         d1_dvd_ff[k+1]  <= {d1_dvd_ff[k][T_W-2:0], 1'b0};
         d1_q_ff[k+1]    <= {d1_q_ff[k][T_W-2:0], ge};
         d1_side_ff[k+1] <= d1_side_ff[k];
      end
   end

   // ---------------- stage e: signed tca, outside test, partial squares ----------------
   logic [T_W-1:0]        tcam;
   logic [T_W:0]          tcam_ext;
   logic signed [T_W:0]   tca;
   logic signed [T_W:0]   tol_tca;
   logic [HALF_W-1:0]     tc_lo;
   logic [HI_W-1:0]       tc_hi;

   assign tcam     = d1_q_ff[T_W];
   assign tcam_ext = {1'b0, tcam};
   assign tca      = d1_side_ff[T_W].pd_neg ? $signed(tcam_ext) : -$signed(tcam_ext);
   assign tol_tca  = $signed({{(T_W+1-TOL_W){1'b0}}, tol_ff});
   assign tc_lo    = tcam[HALF_W-1:0];
   assign tc_hi    = tcam[T_W-1:HALF_W];

   logic                   e_vld_ff;
   logic                   e_dead_ff;
   logic [SUM_W-1:0]       e_pp_ff;
   logic [LEN_W-1:0]       e_len_ff;
   logic [T_W:0]           e_tca_ff;
   logic [2*HALF_W-1:0]    e_ll_ff;
   logic [HALF_W+HI_W-1:0] e_lh_ff;
   logic [2*HI_W-1:0]      e_hh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= d1_vld_ff[T_W];
      end
   end

   always_ff @(posedge clock) begin
      e_dead_ff <= d1_side_ff[T_W].dead | (~d1_side_ff[T_W].org_in & (tca < tol_tca));
      e_pp_ff   <= d1_side_ff[T_W].pp;
      e_len_ff  <= d1_side_ff[T_W].len;
      e_tca_ff  <= tca;
      e_ll_ff   <= tc_lo * tc_lo;
      e_lh_ff   <= tc_lo * tc_hi;
      e_hh_ff   <= tc_hi * tc_hi;
   end

   // ---------------- stage f: tca^2 + 1.0 ----------------
   logic             f_vld_ff;
   logic             f_dead_ff;
   logic [SUM_W-1:0] f_pp_ff;
   logic [LEN_W-1:0] f_len_ff;
   logic [T_W:0]     f_tca_ff;
   logic [H2_W-1:0]  f_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      f_dead_ff <= e_dead_ff;
      f_pp_ff   <= e_pp_ff;
      f_len_ff  <= e_len_ff;
      f_tca_ff  <= e_tca_ff;
      f_a_ff    <= ({{(H2_W-2*HI_W){1'b0}}, e_hh_ff} << (2 * HALF_W))
                 + ({{(H2_W-HALF_W-HI_W){1'b0}}, e_lh_ff} << (HALF_W + 1))
                 + {{(H2_W-2*HALF_W){1'b0}}, e_ll_ff}
                 + ONE_H2;
   end

   // ---------------- stage g: squared half chord ----------------
   logic [H2_W-1:0]  pp_h2;
   logic             g_vld_ff;
   logic             g_dead_ff;
   logic [LEN_W-1:0] g_len_ff;
   logic [T_W:0]     g_tca_ff;
   logic [H2_W-1:0]  g_h2_ff;

   assign pp_h2 = {{(H2_W-SUM_W){1'b0}}, f_pp_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else begin
         g_vld_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      g_dead_ff <= f_dead_ff | (f_a_ff < pp_h2);
      g_len_ff  <= f_len_ff;
      g_tca_ff  <= f_tca_ff;
      g_h2_ff   <= f_a_ff - pp_h2;
   end

   // ---------------- square root of the squared half chord ----------------
   logic [H2_W-1:0] tol_h2;
   assign tol_h2 = {{(H2_W-TOL_W-FRAC_BITS){1'b0}}, tol_ff, {FRAC_BITS{1'b0}}};

   logic            s2_vld_ff  [0:HC_W];
   logic [HC_W:0]   s2_rem_ff  [0:HC_W];
   logic [HC_W-1:0] s2_root_ff [0:HC_W];
   logic [H2_W-1:0] s2_rad_ff  [0:HC_W];
   side3_type       s2_side_ff [0:HC_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff[0] <= 1'b0;
      end else begin
         s2_vld_ff[0] <= g_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_rem_ff[0]       <= '0;
      s2_root_ff[0]      <= '0;
      s2_rad_ff[0]       <= g_h2_ff;
      s2_side_ff[0].dead <= g_dead_ff | (g_h2_ff < tol_h2);
      s2_side_ff[0].tca  <= g_tca_ff;
      s2_side_ff[0].len  <= g_len_ff;
   end

   for (genvar k = 0; k < HC_W; k++) begin : g_sqrt2
      logic [HC_W+1:0] cur;
      logic [HC_W+1:0] trial;
      logic [HC_W+1:0] diff;
      logic            ge;

      assign cur   = {s2_rem_ff[k][HC_W-1:0], s2_rad_ff[k][H2_W-1 -: 2]};
      assign trial = {s2_root_ff[k], 2'b01};
      assign diff  = cur - trial;
      assign ge    = (cur >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            s2_vld_ff[k+1] <= 1'b0;
         end else begin
            s2_vld_ff[k+1] <= s2_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         s2_rem_ff[k+1]  <= ge ? diff[HC_W:0] : cur[HC_W:0];
         s2_root_ff[k+1] <= {s2_root_ff[k][HC_W-2:0], ge};
         s2_rad_ff[k+1]  <= {s2_rad_ff[k][H2_W-3:0], 2'b00};
         s2_side_ff[k+1] <= s2_side_ff[k];
      end
   end

   // ---------------- root numerators and the two root dividers ----------------
   logic signed [NUM_W-1:0] tca_n;
   logic signed [NUM_W-1:0] hc_n;
   logic signed [NUM_W-1:0] num1;
   logic signed [NUM_W-1:0] num2;

   assign tca_n = $signed({{(NUM_W-T_W-1){s2_side_ff[HC_W].tca[T_W]}}, s2_side_ff[HC_W].tca});
   assign hc_n  = $signed({{(NUM_W-HC_W){1'b0}}, s2_root_ff[HC_W]});
   assign num1  = tca_n + hc_n;
   assign num2  = tca_n - hc_n;

   logic             q2_vld_ff  [0:DV_W];
   logic [LEN_W-1:0] q2_rem1_ff [0:DV_W];
   logic [LEN_W-1:0] q2_rem2_ff [0:DV_W];
   logic [DV_W-1:0]  q2_dvd1_ff [0:DV_W];
   logic [DV_W-1:0]  q2_dvd2_ff [0:DV_W];
   logic [DV_W-1:0]  q2_q1_ff   [0:DV_W];
   logic [DV_W-1:0]  q2_q2_ff   [0:DV_W];
   side4_type        q2_side_ff [0:DV_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         q2_vld_ff[0] <= 1'b0;
      end else begin
         q2_vld_ff[0] <= s2_vld_ff[HC_W];
      end
   end

   always_ff @(posedge clock) begin
      q2_rem1_ff[0] <= '0;
      q2_rem2_ff[0] <= '0;
      q2_dvd1_ff[0] <= {(num1[NUM_W-1] ? -num1 : num1), {FRAC_BITS{1'b0}}};
      q2_dvd2_ff[0] <= {(num2[NUM_W-1] ? -num2 : num2), {FRAC_BITS{1'b0}}};
      q2_q1_ff[0]   <= '0;
      q2_q2_ff[0]   <= '0;
      q2_side_ff[0].dead <= s2_side_ff[HC_W].dead;
      q2_side_ff[0].neg1 <= num1[NUM_W-1];
      q2_side_ff[0].neg2 <= num2[NUM_W-1];
      q2_side_ff[0].len  <= s2_side_ff[HC_W].len;
   end

   for (genvar k = 0; k < DV_W; k++) begin : g_div2
      logic [LEN_W:0] cur1;
      logic [LEN_W:0] cur2;
      logic [LEN_W:0] diff1;
      logic [LEN_W:0] diff2;
      logic           ge1;
      logic           ge2;

      assign cur1  = {q2_rem1_ff[k], q2_dvd1_ff[k][DV_W-1]};
      assign cur2  = {q2_rem2_ff[k], q2_dvd2_ff[k][DV_W-1]};
      assign diff1 = cur1 - {1'b0, q2_side_ff[k].len};
      assign diff2 = cur2 - {1'b0, q2_side_ff[k].len};
      assign ge1   = (cur1 >= {1'b0, q2_side_ff[k].len});
      assign ge2   = (cur2 >= {1'b0, q2_side_ff[k].len});

      always_ff @(posedge clock) begin
         if (reset) begin
            q2_vld_ff[k+1] <= 1'b0;
         end else begin
            q2_vld_ff[k+1] <= q2_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         q2_rem1_ff[k+1] <= ge1 ? diff1[LEN_W-1:0] : cur1[LEN_W-1:0];
         q2_rem2_ff[k+1] <= ge2 ? diff2[LEN_W-1:0] : cur2[LEN_W-1:0];
         q2_dvd1_ff[k+1] <= {q2_dvd1_ff[k][DV_W-2:0], 1'b0};
         q2_dvd2_ff[k+1] <= {q2_dvd2_ff[k][DV_W-2:0], 1'b0};
         q2_q1_ff[k+1]   <= {q2_q1_ff[k][DV_W-2:0], ge1};
         q2_q2_ff[k+1]   <= {q2_q2_ff[k][DV_W-2:0], ge2};
         q2_side_ff[k+1] <= q2_side_ff[k];
      end
   end

   // ---------------- output stage: range tests and root substitution ----------------
   logic [RT_W-1:0]        q1_ext;
   logic [RT_W-1:0]        q2_ext;
   logic signed [RT_W-1:0] r1;
   logic signed [RT_W-1:0] r2;
   logic signed [RT_W-1:0] tol_rt;
   logic signed [RT_W-1:0] maxd_rt;
   logic                   acc1;
   logic                   acc2;
   logic                   rsp_strobe_ff;
   rusi_pkg::rusi_rsp_type rsp_data_ff;
   rusi_pkg::rusi_rsp_type rsp_data_in;

   assign q1_ext  = {1'b0, q2_q1_ff[DV_W]};
   assign q2_ext  = {1'b0, q2_q2_ff[DV_W]};
   assign r1      = q2_side_ff[DV_W].neg1 ? -$signed(q1_ext) : $signed(q1_ext);
   assign r2      = q2_side_ff[DV_W].neg2 ? -$signed(q2_ext) : $signed(q2_ext);
   assign tol_rt  = $signed({{(RT_W-TOL_W){1'b0}}, tol_ff});
   assign maxd_rt = $signed({{(RT_W-MAXD_W){1'b0}}, maxd_ff});
   assign acc1    = (r1 >= tol_rt) && (r1 <= maxd_rt);
   assign acc2    = (r2 >= tol_rt) && (r2 <= maxd_rt);

   always_comb begin
      rsp_data_in = '0;
      if (!q2_side_ff[DV_W].dead && (acc1 || acc2)) begin
         rsp_data_in.hit        = 1'b1;
         rsp_data_in.depth_far  = acc1 ? r1[CW-1:0] : r2[CW-1:0];
         rsp_data_in.depth_near = acc2 ? r2[CW-1:0] : r1[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= q2_vld_ff[DV_W];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // ---------------- assertions ----------------
   a_no_strobe_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   a_miss_clears_depths: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.hit |-> rsp_data.depth_far == '0 && rsp_data.depth_near == '0)
      else $error("miss transfer carries nonzero depths");

   a_hit_depths_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.hit |-> !rsp_data.depth_far[CW-1] && !rsp_data.depth_near[CW-1])
      else $error("hit transfer carries a negative depth");

   a_far_not_below_near: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.hit |-> $signed(rsp_data.depth_far) >= $signed(rsp_data.depth_near))
      else $error("far depth below near depth");

endmodule

### tb/sv/ray_unit_sphere_intersect_unit_tb.sv
// Self-checking testbench for the pipelined ray against unit sphere intersection unit.
`timescale 1ns / 1ps

module ray_unit_sphere_intersect_unit_tb;

   localparam int FB = rusi_pkg::FRAC_BITS_DEF;
   localparam int LATENCY = 149 + FB;
   localparam longint CYCLE_LIMIT = 1500000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   rusi_pkg::rusi_req_type req_data = '0;
   logic rsp_strobe;
   rusi_pkg::rusi_rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [rusi_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [rusi_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [rusi_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   ray_unit_sphere_intersect_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor copy of the two registers.
   logic [rusi_pkg::TOL_W-1:0] tol_reg = rusi_pkg::TOL_RESET;
   logic [rusi_pkg::MAXD_W-1:0] maxd_reg = rusi_pkg::MAXD_RESET;

   rusi_pkg::rusi_rsp_type hit_queue[$];
   int mismatches = 0;
   int results_seen = 0;
   int hits_seen = 0;
   int rays_sent = 0;
   longint cycles = 0;

   function automatic logic [63:0] isqrt128(logic [127:0] v);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         c = r | (64'd1 << i);
         if ({64'd0, c} * {64'd0, c} <= v) r = c;
      end
      return r;
   endfunction

   function automatic logic signed [95:0] div_root(logic signed [95:0] num,
                                                  logic [63:0] len);
      logic [127:0] m;
      logic [127:0] q;
      m = num < 0 ? 128'(-num) : 128'(num);
      q = (m << FB) / {64'd0, len};
      return num < 0 ? -96'(signed'(q[95:0])) : 96'(signed'(q[95:0]));
   endfunction

   function automatic bit depth_ok(logic signed [95:0] r);
      return r >= $signed({79'd0, tol_reg}) && r <= $signed({65'd0, maxd_reg});
   endfunction

   function automatic rusi_pkg::rusi_rsp_type sphere_predict(rusi_pkg::rusi_req_type rq);
      logic signed [127:0] p[3], d[3];
      logic signed [127:0] dd, pp, pd, tca, h2, one2;
      logic [63:0] len, hc;
      logic signed [95:0] r1, r2;
      rusi_pkg::rusi_rsp_type rs;
      rs = '0;
      p[0] = 128'(rq.origin_x); p[1] = 128'(rq.origin_y); p[2] = 128'(rq.origin_z);
      d[0] = 128'(rq.dir_x); d[1] = 128'(rq.dir_y); d[2] = 128'(rq.dir_z);
      dd = 0; pp = 0; pd = 0;
      for (int i = 0; i < 3; i++) begin
         dd += d[i] * d[i];
         pp += p[i] * p[i];
         pd += p[i] * d[i];
      end
      if (dd == 0) return rs;
      len = isqrt128(dd);
      // Signed division in SystemVerilog truncates toward zero.
      tca = -pd / $signed({64'd0, len});
      one2 = 128'sd1 << (2 * FB);
      if (pp >= one2 && tca < $signed({111'd0, tol_reg})) return rs;
      h2 = tca * tca + one2 - pp;
      if (h2 < 0) return rs;
      if (h2 < $signed({111'd0, tol_reg} << FB)) return rs;
      hc = isqrt128(h2);
      r1 = div_root(96'(tca + $signed({64'd0, hc})), len);
      r2 = div_root(96'(tca - $signed({64'd0, hc})), len);
      if (!depth_ok(r1)) begin
         if (!depth_ok(r2)) return rs;
         r1 = r2;
      end else if (!depth_ok(r2)) begin
         r2 = r1;
      end
      rs.hit = 1'b1;
      rs.depth_far = r1[31:0];
      rs.depth_near = r2[31:0];
      return rs;
   endfunction

   // Results are accepted on the rising edge; the receiver can never stall.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_strobe) begin
         results_seen <= results_seen + 1;
         if (hit_queue.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected result %p", rsp_data);
         end else begin
            if (hit_queue[0].hit) hits_seen <= hits_seen + 1;
            if (rsp_data !== hit_queue[0]) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: expected %p, got %p", hit_queue[0], rsp_data);
            end
            void'(hit_queue.pop_front());
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic csr_write(logic idx, logic [31:0] value);
      @(negedge clock);
      psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
      paddr = {idx, 2'b00}; pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == rusi_pkg::CSR_TOL_IDX) tol_reg = value[rusi_pkg::TOL_W-1:0];
      else maxd_reg = value[rusi_pkg::MAXD_W-1:0];
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   // One ray transfer: start held at the falling edge until accepted.
   task automatic send_ray(rusi_pkg::rusi_req_type rq);
      @(negedge clock);
      req_data = rq;
      start = 1'b1;
      do @(posedge clock); while (busy);
      hit_queue.push_back(sphere_predict(rq));
      rays_sent++;
      @(negedge clock);
      start = 1'b0;
   endtask

   // Sends in bursts; start stays high across back-to-back transfers.
   task automatic send_burst(rusi_pkg::rusi_req_type rq[$]);
      foreach (rq[i]) begin
         if (i == 0) @(negedge clock);
         req_data = rq[i];
         start = 1'b1;
         do @(posedge clock); while (busy);
         hit_queue.push_back(sphere_predict(rq[i]));
         rays_sent++;
         @(negedge clock);
      end
      start = 1'b0;
   endtask

   task automatic drain();
      while (hit_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic [31:0] q16(int v);
      return 32'(v <<< 16);
   endfunction

   function automatic rusi_pkg::rusi_req_type make_ray(logic [31:0] ox, oy, oz, dx, dy, dz);
      rusi_pkg::rusi_req_type r;
      r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
      r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
      return r;
   endfunction

   function automatic logic [31:0] rand_coord(int scale);
      case (scale)
         0: return 32'($signed($urandom_range(0, 262144)) - 131072);
         1: return 32'($signed($urandom_range(0, 1048576)) - 524288);
         2: return 32'($signed($urandom_range(0, 8388608)) - 4194304);
         default: return $urandom;
      endcase
   endfunction

   function automatic rusi_pkg::rusi_req_type rand_ray();
      rusi_pkg::rusi_req_type r;
      int s;
      s = $urandom_range(0, 9);
      s = s < 4 ? 1 : s < 7 ? 2 : s < 9 ? 0 : 3;
      r = make_ray(rand_coord(s), rand_coord(s), rand_coord(s),
                   rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)),
                   rand_coord($urandom_range(0, 3)));
      // Aim most rays back toward the sphere so many of them hit.
      if ($urandom_range(0, 3) != 0) begin
         r.dir_x = -r.origin_x + rand_coord(0);
         r.dir_y = -r.origin_y + rand_coord(0);
         r.dir_z = -r.origin_z + rand_coord(0);
      end
      return r;
   endfunction

   task automatic test_directed();
      rusi_pkg::rusi_req_type r;
      send_ray(make_ray(q16(0), q16(0), q16(-3), q16(0), q16(0), q16(1)));
      send_ray(make_ray(q16(0), q16(0), q16(-3), q16(0), q16(0), q16(-1)));
      send_ray(make_ray(q16(0), q16(0), q16(0), q16(0), q16(0), q16(2)));
      send_ray(make_ray(q16(0), q16(0), q16(0), 0, 0, 0));
      send_ray(make_ray(q16(0), q16(2), q16(-3), q16(0), q16(0), q16(1)));
      send_ray(make_ray(q16(0), q16(1), q16(-3), q16(0), q16(0), q16(1)));
      send_ray(make_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_ray(make_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_ray(make_ray(q16(-30000), 0, 0, 1, 0, 0));
      send_ray(make_ray(q16(-5), 0, 0, 1, 0, 0));
      send_ray(make_ray(0, 0, 0, 32'hFFFF_FFFF, 0, 0));
      send_ray(make_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1));
      r = make_ray(q16(0), q16(0), q16(5), q16(0), q16(0), q16(-1));
      send_ray(r);
      drain();
   endtask

   task automatic test_register_settings();
      csr_write(rusi_pkg::CSR_TOL_IDX, 32'd0);
      csr_write(rusi_pkg::CSR_MAXD_IDX, 32'd0);
      for (int i = 0; i < 8; i++) send_ray(rand_ray());
      send_ray(make_ray(0, 0, 0, q16(0), q16(1), 0));
      drain();
      csr_write(rusi_pkg::CSR_TOL_IDX, 32'h1FFFF);
      csr_write(rusi_pkg::CSR_MAXD_IDX, q16(3));
      send_ray(make_ray(q16(0), q16(0), q16(-3), q16(0), q16(0), q16(1)));
      send_ray(make_ray(0, 0, 0, q16(0), q16(1), 0));
      for (int i = 0; i < 8; i++) send_ray(rand_ray());
      drain();
   endtask

   task automatic test_random_streams(int count);
      rusi_pkg::rusi_req_type burst[$];
      int n;
      while (count > 0) begin
         burst.delete();
         n = $urandom_range(1, 40);
         for (int i = 0; i < n; i++) burst.push_back(rand_ray());
         send_burst(burst);
         count -= n;
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      drain();
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 4; phase++) begin
         csr_write(rusi_pkg::CSR_TOL_IDX,
                   $urandom_range(0, 2) == 0 ? 32'h10000 : $urandom_range(0, 2000));
         csr_write(rusi_pkg::CSR_MAXD_IDX,
                   phase == 3 ? 32'h7FFF_FFFF : $urandom_range(0, 32'h0040_0000));
         test_random_streams(300);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_register_settings();
      csr_write(rusi_pkg::CSR_TOL_IDX, 32'd66);
      csr_write(rusi_pkg::CSR_MAXD_IDX, 32'h7FFF_FFFF);
      test_random_streams(350);
      test_random_settings();
      $display("rays sent %0d, results checked %0d, hits %0d",
               rays_sent, results_seen, hits_seen);
      $display("covered register extremes, random settings and bursty streams");
      if (mismatches == 0 && hit_queue.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/rusi_pkg.sv
hdl/ray_unit_sphere_intersect_unit.sv
tb/sv/ray_unit_sphere_intersect_unit_tb.sv
